// ===== rtl/core/fbw_pkg.sv =====
// fbw_pkg: shared types and constants of the flow bilinear backward warp.
// Used by fbw_front, fbw_back and the top level under rtl/core; depends on nothing.
package fbw_pkg;

   localparam int PIXEL_W     = 16;
   localparam int POS_W       = 9;
   localparam int FLOW_W      = 18;
   localparam int FRAC_W      = 6;
   // displaced point: pos*64 + flow, signed
   localparam int SX_W        = 19;
   // width of a column or row index the block supports (12 bits, 4096 pixels)
   localparam int COORD_W     = SX_W - 1 - FRAC_W;
   localparam int WEIGHT_W    = 2 * FRAC_W + 1;
   localparam int PROD_W      = 30;
   localparam int PSUM_W      = PROD_W + 1;
   localparam int TOTAL_W     = PROD_W + 2;
   localparam int CSR_DATA_W  = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int FRAME_RESET = 512;
   localparam int MID_DEPTH   = 4;
   localparam int OUT_DEPTH   = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   typedef enum logic {
      REQ_LOAD   = 1'b0,
      REQ_SAMPLE = 1'b1
   } req_kind_type;

   // classified item passed from front to back
   typedef struct packed {
      logic                       is_load;
      logic                       outside;
      logic [COORD_W-1:0]         col;
      logic [COORD_W-1:0]         row;
      logic [FRAC_W-1:0]          frac_x;
      logic [FRAC_W-1:0]          frac_y;
      logic                       clamp_x;
      logic                       clamp_y;
      logic signed [PIXEL_W-1:0]  pixel;
   } op_type;

   typedef struct packed {
      logic signed [PIXEL_W-1:0]  sample_value;
      logic                       outside_frame;
   } rsp_type;

endpackage

// ===== rtl/core/fbw_fifo.sv =====
// fbw_fifo: small register queue with push/full and pop/empty sides.
// Generic; no package dependency.
module fbw_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign dout    = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ===== rtl/core/fbw_front.sv =====
// fbw_front: classifies each accepted item into a store write or a sample,
// computes the displaced point, the plane test, cell and fractions. Uses fbw_pkg.
module fbw_front #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic [$clog2(MAX_WIDTH+1)-1:0]    frame_w,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]   frame_h,
   input  logic                              req_type,
   input  logic [fbw_pkg::POS_W-1:0]         pos_x,
   input  logic [fbw_pkg::POS_W-1:0]         pos_y,
   input  logic signed [fbw_pkg::PIXEL_W-1:0] pixel_value,
   input  logic signed [fbw_pkg::FLOW_W-1:0]  flow_x,
   input  logic signed [fbw_pkg::FLOW_W-1:0]  flow_y,
   output fbw_pkg::op_type                   op,
   output logic                              keep
);

   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int HW     = $clog2(MAX_HEIGHT + 1);
   localparam int MAG_W  = fbw_pkg::SX_W - 1;
   localparam int CMPX_W = (MAG_W > WW + fbw_pkg::FRAC_W) ? MAG_W : WW + fbw_pkg::FRAC_W;
   localparam int CMPY_W = (MAG_W > HW + fbw_pkg::FRAC_W) ? MAG_W : HW + fbw_pkg::FRAC_W;
   localparam int LDX_W  = (fbw_pkg::POS_W > WW) ? fbw_pkg::POS_W : WW;
   localparam int LDY_W  = (fbw_pkg::POS_W > HW) ? fbw_pkg::POS_W : HW;

   logic signed [fbw_pkg::SX_W-1:0]  sx, sy;
   logic [MAG_W-1:0]                 mag_x, mag_y;
   logic [WW-1:0]                    w_m1;
   logic [HW-1:0]                    h_m1;
   logic [CMPX_W-1:0]                lim_x;
   logic [CMPY_W-1:0]                lim_y;
   logic [fbw_pkg::COORD_W-1:0]      cell_x, cell_y;
   logic                             is_load, in_plane_load, outside;

   always_comb begin
      sx = fbw_pkg::SX_W'($signed({1'b0, pos_x, {fbw_pkg::FRAC_W{1'b0}}}))
           + fbw_pkg::SX_W'(flow_x);
      sy = fbw_pkg::SX_W'($signed({1'b0, pos_y, {fbw_pkg::FRAC_W{1'b0}}}))
           + fbw_pkg::SX_W'(flow_y);
      mag_x = sx[MAG_W-1:0];
      mag_y = sy[MAG_W-1:0];
      w_m1  = frame_w - 1'b1;
      h_m1  = frame_h - 1'b1;
      lim_x = CMPX_W'({w_m1, {fbw_pkg::FRAC_W{1'b0}}});
      lim_y = CMPY_W'({h_m1, {fbw_pkg::FRAC_W{1'b0}}});
      // last column and last row are inside
      outside = sx[fbw_pkg::SX_W-1] | sy[fbw_pkg::SX_W-1]
                | (CMPX_W'(mag_x) > lim_x) | (CMPY_W'(mag_y) > lim_y);
      cell_x = fbw_pkg::COORD_W'(mag_x >> fbw_pkg::FRAC_W);
      cell_y = fbw_pkg::COORD_W'(mag_y >> fbw_pkg::FRAC_W);

      is_load       = (req_type == fbw_pkg::REQ_LOAD);
      in_plane_load = (LDX_W'(pos_x) < LDX_W'(frame_w))
                      & (LDY_W'(pos_y) < LDY_W'(frame_h));
      keep          = ~is_load | in_plane_load;

      op.is_load = is_load;
      op.outside = outside;
      op.pixel   = pixel_value;
      if (is_load) begin
         op.col     = fbw_pkg::COORD_W'(pos_x);
         op.row     = fbw_pkg::COORD_W'(pos_y);
         op.frac_x  = '0;
         op.frac_y  = '0;
         op.clamp_x = 1'b0;
         op.clamp_y = 1'b0;
      end else begin
         op.col     = cell_x;
         op.row     = cell_y;
         op.frac_x  = mag_x[fbw_pkg::FRAC_W-1:0];
         op.frac_y  = mag_y[fbw_pkg::FRAC_W-1:0];
         // right / lower neighbor folds back onto the cell at the plane edge
         op.clamp_x = (cell_x == fbw_pkg::COORD_W'(w_m1));
         op.clamp_y = (cell_y == fbw_pkg::COORD_W'(h_m1));
      end
   end

endmodule

// ===== rtl/core/fbw_back.sv =====
// fbw_back: plane store in four parity banks, bilinear blend pipeline and
// result credit tracking. Uses fbw_pkg.
module fbw_back #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  fbw_pkg::op_type  q_op,
   output logic             q_pop,
   input  logic             rsp_taken,
   output logic             res_valid,
   output fbw_pkg::rsp_type res
);

   localparam int XW         = $clog2(MAX_WIDTH);
   localparam int YW         = $clog2(MAX_HEIGHT);
   localparam int BXW        = (XW > 1) ? XW - 1 : 1;
   localparam int BYW        = (YW > 1) ? YW - 1 : 1;
   localparam int BAW        = BXW + BYW;
   localparam int BANK_DEPTH = 1 << BAW;
   localparam int PW         = $clog2(fbw_pkg::OUT_DEPTH + 1);
   localparam int PX_W       = fbw_pkg::PIXEL_W;
   localparam int FW         = fbw_pkg::FRAC_W;
   localparam int TW         = fbw_pkg::TOTAL_W;
   localparam int SHIFT      = 2 * FW;
   localparam logic signed [TW-1:0] ROUND  = TW'(1 << (SHIFT - 1));
   localparam logic signed [TW-1:0] SAT_HI = TW'((1 << (PX_W - 1)) - 1);
   localparam logic signed [TW-1:0] SAT_LO = -TW'(1 << (PX_W - 1));

   // ---------------- issue ----------------
   logic          issue, is_sample, rd_en;
   logic [PW-1:0] pending_ff, pending_in;

   assign issue     = ~q_empty & (q_op.is_load | (pending_ff < PW'(fbw_pkg::OUT_DEPTH)));
   assign q_pop     = issue;
   assign is_sample = issue & ~q_op.is_load;
   assign rd_en     = is_sample & ~q_op.outside;

   // samples in flight plus results waiting in the output queue
   always_comb begin
      pending_in = pending_ff;
      if (is_sample && !rsp_taken) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_taken && !is_sample) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // ---------------- banked store ----------------
   // bank [by][bx] holds pixels with row parity by and column parity bx
   logic signed [PX_W-1:0] rd_ff [2][2];

   for (genvar gy = 0; gy < 2; gy++) begin : g_row
      for (genvar gx = 0; gx < 2; gx++) begin : g_col
         logic signed [PX_W-1:0]        store_ff [BANK_DEPTH];
         logic [fbw_pkg::COORD_W-1:0]   col_b, row_b;
         logic [BAW-1:0]                addr_b;
         logic                          we_b;

         assign col_b  = (q_op.col[0] == 1'(gx)) ? q_op.col : q_op.col + 1'b1;
         assign row_b  = (q_op.row[0] == 1'(gy)) ? q_op.row : q_op.row + 1'b1;
         assign addr_b = {BYW'(row_b >> 1), BXW'(col_b >> 1)};
         assign we_b   = issue & q_op.is_load
                         & (q_op.col[0] == 1'(gx)) & (q_op.row[0] == 1'(gy));

         always_ff @(posedge clock) begin
            if (we_b) begin
               store_ff[addr_b] <= q_op.pixel;
            end
            if (rd_en) begin
               rd_ff[gy][gx] <= store_ff[addr_b];
            end
         end
      end
   end

   // ---------------- stage 1: weights ----------------
   logic [FW:0]                   wx0, wx1, wy0, wy1;
   logic [fbw_pkg::WEIGHT_W-1:0]  w_in [4];
   logic [fbw_pkg::WEIGHT_W-1:0]  s1_w_ff [4];
   logic                          s1_valid_ff, s1_outside_ff;
   logic                          s1_clamp_x_ff, s1_clamp_y_ff, s1_par_x_ff, s1_par_y_ff;

   always_comb begin
      wx0 = {1'b1, {FW{1'b0}}} - {1'b0, q_op.frac_x};
      wx1 = {1'b0, q_op.frac_x};
      wy0 = {1'b1, {FW{1'b0}}} - {1'b0, q_op.frac_y};
      wy1 = {1'b0, q_op.frac_y};
      w_in[0] = fbw_pkg::WEIGHT_W'(wx0) * fbw_pkg::WEIGHT_W'(wy0);
      w_in[1] = fbw_pkg::WEIGHT_W'(wx1) * fbw_pkg::WEIGHT_W'(wy0);
      w_in[2] = fbw_pkg::WEIGHT_W'(wx0) * fbw_pkg::WEIGHT_W'(wy1);
      w_in[3] = fbw_pkg::WEIGHT_W'(wx1) * fbw_pkg::WEIGHT_W'(wy1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= is_sample;
      end
   end

   always_ff @(posedge clock) begin
      s1_outside_ff <= q_op.outside;
      s1_clamp_x_ff <= q_op.clamp_x;
      s1_clamp_y_ff <= q_op.clamp_y;
      s1_par_x_ff   <= q_op.col[0];
      s1_par_y_ff   <= q_op.row[0];
      for (int i = 0; i < 4; i++) begin
         s1_w_ff[i] <= w_in[i];
      end
   end

   // ---------------- stage 2: neighbor select and products ----------------
   logic signed [PX_W-1:0]           near_row [2], far_row [2];
   logic signed [PX_W-1:0]           d_sel [4];
   logic signed [fbw_pkg::PROD_W-1:0] p_in [4];
   logic signed [fbw_pkg::PROD_W-1:0] s2_p_ff [4];
   logic                             s2_valid_ff, s2_outside_ff;

   always_comb begin
      for (int bx = 0; bx < 2; bx++) begin
         near_row[bx] = s1_par_y_ff ? rd_ff[1][bx] : rd_ff[0][bx];
         far_row[bx]  = s1_par_y_ff ? rd_ff[0][bx] : rd_ff[1][bx];
      end
      d_sel[0] = s1_par_x_ff ? near_row[1] : near_row[0];
      d_sel[1] = s1_clamp_x_ff ? d_sel[0]
                 : (s1_par_x_ff ? near_row[0] : near_row[1]);
      d_sel[2] = s1_clamp_y_ff ? d_sel[0]
                 : (s1_par_x_ff ? far_row[1] : far_row[0]);
      if (s1_clamp_x_ff) begin
         d_sel[3] = d_sel[2];
      end else if (s1_clamp_y_ff) begin
         d_sel[3] = d_sel[1];
      end else begin
         d_sel[3] = s1_par_x_ff ? far_row[0] : far_row[1];
      end
      for (int i = 0; i < 4; i++) begin
         p_in[i] = $signed({1'b0, s1_w_ff[i]}) * d_sel[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_outside_ff <= s1_outside_ff;
      for (int i = 0; i < 4; i++) begin
         s2_p_ff[i] <= p_in[i];
      end
   end

   // ---------------- stage 3: pair sums ----------------
   logic signed [fbw_pkg::PSUM_W-1:0] sum_a_in, sum_b_in, s3_a_ff, s3_b_ff;
   logic                              s3_valid_ff, s3_outside_ff;

   assign sum_a_in = fbw_pkg::PSUM_W'(s2_p_ff[0]) + fbw_pkg::PSUM_W'(s2_p_ff[1]);
   assign sum_b_in = fbw_pkg::PSUM_W'(s2_p_ff[2]) + fbw_pkg::PSUM_W'(s2_p_ff[3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_outside_ff <= s2_outside_ff;
      s3_a_ff       <= sum_a_in;
      s3_b_ff       <= sum_b_in;
   end

   // ---------------- final: round half up, floor, saturate, zero outside ----------------
   logic signed [TW-1:0] total, scaled;

   always_comb begin
      total  = TW'(s3_a_ff) + TW'(s3_b_ff) + ROUND;
      scaled = total >>> SHIFT;
      res_valid = s3_valid_ff;
      res.outside_frame = s3_outside_ff;
      if (s3_outside_ff) begin
         res.sample_value = '0;
      end else if (scaled > SAT_HI) begin
         res.sample_value = PX_W'(SAT_HI);
      end else if (scaled < SAT_LO) begin
         res.sample_value = PX_W'(SAT_LO);
      end else begin
         res.sample_value = PX_W'(scaled);
      end
   end

endmodule

// ===== rtl/core/flow_bilinear_backward_warp.sv =====
// flow_bilinear_backward_warp: top level, frame size registers, front/back
// split with queues. Uses fbw_pkg, fbw_front, fbw_fifo, fbw_back.
//
// Takes one item per clock, loads and samples alike, with no gaps as long as
// results are popped. A sample passes through the mid queue, the banked store
// read, the products, the pair sums and the rounding into the output queue
// before its result appears on the result side. The store is four single-port
// banks split by row and column parity, so the four neighbors of a sample are
// read in the same cycle; a load is one bank write. Up to eight samples may be
// outstanding; beyond that the block holds items back until results are
// popped. Pixels must be loaded before any sample reads them; the store has no
// clear after reset. Frame size writes must be made only while no item is in
// flight; the block itself does not enforce it.
module flow_bilinear_backward_warp #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                req_type,
   input  logic [fbw_pkg::POS_W-1:0]           req_pos_x,
   input  logic [fbw_pkg::POS_W-1:0]           req_pos_y,
   input  logic signed [fbw_pkg::PIXEL_W-1:0]  req_pixel_value,
   input  logic signed [fbw_pkg::FLOW_W-1:0]   req_flow_x,
   input  logic signed [fbw_pkg::FLOW_W-1:0]   req_flow_y,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [fbw_pkg::PIXEL_W-1:0]  rsp_sample_value,
   output logic                                rsp_outside_frame,
   input  logic                                csr_write_en,
   input  logic [fbw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fbw_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int CLW  = (fbw_pkg::CSR_DATA_W > WW) ? fbw_pkg::CSR_DATA_W : WW;
   localparam int CLH  = (fbw_pkg::CSR_DATA_W > HW) ? fbw_pkg::CSR_DATA_W : HW;
   localparam int RST_W = (fbw_pkg::FRAME_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                             : fbw_pkg::FRAME_RESET;
   localparam int RST_H = (fbw_pkg::FRAME_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                              : fbw_pkg::FRAME_RESET;
   localparam int OP_W  = $bits(fbw_pkg::op_type);
   localparam int RSP_W = $bits(fbw_pkg::rsp_type);

   // ---------------- frame size registers (stored already clamped) ----------------
   logic [WW-1:0]  frame_w_ff, frame_w_in;
   logic [HW-1:0]  frame_h_ff, frame_h_in;
   logic [CLW-1:0] wd_w;
   logic [CLH-1:0] wd_h;

   always_comb begin
      wd_w       = CLW'(csr_wdata);
      wd_h       = CLH'(csr_wdata);
      frame_w_in = frame_w_ff;
      frame_h_in = frame_h_ff;
      if (csr_write_en) begin
         case (fbw_pkg::csr_index_type'(csr_index))
            fbw_pkg::CSR_FRAME_WIDTH: begin
               if (wd_w == '0) begin
                  frame_w_in = WW'(1);
               end else if (wd_w > CLW'(MAX_WIDTH)) begin
                  frame_w_in = WW'(MAX_WIDTH);
               end else begin
                  frame_w_in = WW'(wd_w);
               end
            end
            fbw_pkg::CSR_FRAME_HEIGHT: begin
               if (wd_h == '0) begin
                  frame_h_in = HW'(1);
               end else if (wd_h > CLH'(MAX_HEIGHT)) begin
                  frame_h_in = HW'(MAX_HEIGHT);
               end else begin
                  frame_h_in = HW'(wd_h);
               end
            end
            default: begin
               frame_w_in = frame_w_ff;
               frame_h_in = frame_h_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_w_ff <= WW'(RST_W);
         frame_h_ff <= HW'(RST_H);
      end else begin
         frame_w_ff <= frame_w_in;
         frame_h_ff <= frame_h_in;
      end
   end

   // ---------------- front ----------------
   fbw_pkg::op_type front_op, q_op;
   logic            keep, q_full, q_push, q_empty, q_pop;
   logic [OP_W-1:0] q_dout;

   fbw_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .frame_w     (frame_w_ff),
      .frame_h     (frame_h_ff),
      .req_type    (req_type),
      .pos_x       (req_pos_x),
      .pos_y       (req_pos_y),
      .pixel_value (req_pixel_value),
      .flow_x      (req_flow_x),
      .flow_y      (req_flow_y),
      .op          (front_op),
      .keep        (keep)
   );

   assign req_full = q_full;
   // loads outside the plane are accepted and dropped here
   assign q_push   = req_push & ~q_full & keep;

   fbw_fifo #(
      .WIDTH (OP_W),
      .DEPTH (fbw_pkg::MID_DEPTH)
   ) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (front_op),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty)
   );

   assign q_op = fbw_pkg::op_type'(q_dout);

   // ---------------- back ----------------
   logic             res_valid, rsp_taken, out_full;
   fbw_pkg::rsp_type res, rsp_head;
   logic [RSP_W-1:0] out_dout;

   assign rsp_taken = rsp_pop & ~rsp_empty;

   fbw_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_op      (q_op),
      .q_pop     (q_pop),
      .rsp_taken (rsp_taken),
      .res_valid (res_valid),
      .res       (res)
   );

   fbw_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (fbw_pkg::OUT_DEPTH)
   ) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (res_valid),
      .din   (res),
      .full  (out_full),
      .pop   (rsp_pop),
      .dout  (out_dout),
      .empty (rsp_empty)
   );

   assign rsp_head          = fbw_pkg::rsp_type'(out_dout);
   assign rsp_sample_value  = rsp_head.sample_value;
   assign rsp_outside_frame = rsp_head.outside_frame;

   // ---------------- assertions ----------------
   // credit logic must keep room in the output queue for every result
   a_out_room: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !out_full)
      else $error("result produced while output queue full");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_width_floor: assert property (@(posedge clock) disable iff (reset)
      (csr_write_en && csr_index == fbw_pkg::CSR_FRAME_WIDTH && csr_wdata == '0)
      |=> (frame_w_ff == WW'(1)))
      else $error("zero frame width not clamped to one");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_outside_frame) |-> (rsp_sample_value == '0))
      else $error("outside sample carries a nonzero value");

endmodule

// ===== bench/tb_flow_bilinear_backward_warp.sv =====
`timescale 1ns / 100ps
// tb_flow_bilinear_backward_warp: self-checking bench for the flow warp block.
// Keeps its own copy of the plane store and frame size to predict each sample;
// depends on fbw_pkg and the RTL under rtl/core.

module tb_flow_bilinear_backward_warp;

   localparam int PLANE_COLS     = 512;
   localparam int PLANE_ROWS     = 512;
   localparam int FRAC_ONE       = 1 << fbw_pkg::FRAC_W;
   localparam int LOAD_SETTLE    = 8;
   localparam int HOLD_CYCLES    = 150;
   localparam int END_CYCLES     = 20;
   localparam int WATCHDOG_LIMIT = 3000;
   // indexes past the frame size registers, writes must be dropped
   localparam logic [fbw_pkg::CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [fbw_pkg::CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      fbw_pkg::req_kind_type        kind;
      logic [fbw_pkg::POS_W-1:0]    pos_x;
      logic [fbw_pkg::POS_W-1:0]    pos_y;
      logic [fbw_pkg::PIXEL_W-1:0]  pixel;
      logic [fbw_pkg::FLOW_W-1:0]   flow_x;
      logic [fbw_pkg::FLOW_W-1:0]   flow_y;
   } warp_req_type;

   logic                                clock;
   logic                                reset;
   logic                                req_push;
   logic                                req_full;
   logic                                req_type;
   logic [fbw_pkg::POS_W-1:0]           req_pos_x;
   logic [fbw_pkg::POS_W-1:0]           req_pos_y;
   logic signed [fbw_pkg::PIXEL_W-1:0]  req_pixel_value;
   logic signed [fbw_pkg::FLOW_W-1:0]   req_flow_x;
   logic signed [fbw_pkg::FLOW_W-1:0]   req_flow_y;
   logic                                rsp_empty;
   logic                                rsp_pop;
   logic signed [fbw_pkg::PIXEL_W-1:0]  rsp_sample_value;
   logic                                rsp_outside_frame;
   logic                                csr_write_en;
   logic [fbw_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [fbw_pkg::CSR_DATA_W-1:0]      csr_wdata;

   // predicted block state
   logic [fbw_pkg::PIXEL_W-1:0]     plane_pixels [0:PLANE_COLS*PLANE_ROWS-1];
   bit                              plane_loaded [0:PLANE_COLS*PLANE_ROWS-1];
   logic [fbw_pkg::CSR_DATA_W-1:0]  frame_width_reg  =
                                       fbw_pkg::CSR_DATA_W'(fbw_pkg::FRAME_RESET);
   logic [fbw_pkg::CSR_DATA_W-1:0]  frame_height_reg =
                                       fbw_pkg::CSR_DATA_W'(fbw_pkg::FRAME_RESET);
   fbw_pkg::rsp_type                pending_samples [$];

   int  failures           = 0;
   int  counted_items      = 0;
   int  sender_gap_pct     = 20;
   int  receiver_stall_pct = 20;
   bit  hold_results       = 1'b0;
   int  idle_cycles        = 0;

   flow_bilinear_backward_warp #(
      .MAX_WIDTH  (PLANE_COLS),
      .MAX_HEIGHT (PLANE_ROWS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_type          (req_type),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pixel_value   (req_pixel_value),
      .req_flow_x        (req_flow_x),
      .req_flow_y        (req_flow_y),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_outside_frame (rsp_outside_frame),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int frame_dim(input logic [fbw_pkg::CSR_DATA_W-1:0] reg_value,
                                    input int limit);
      int v;
      v = reg_value;
      if (v < 1) v = 1;
      if (v > limit) v = limit;
      return v;
   endfunction

   // displaced point in 1/64 pixel
   function automatic int displaced(input logic [fbw_pkg::POS_W-1:0] pos,
                                    input logic [fbw_pkg::FLOW_W-1:0] flow);
      return int'(pos) * FRAC_ONE + int'($signed(flow));
   endfunction

   function automatic bit inside_plane(input int sx, input int sy);
      int w, h;
      w = frame_dim(frame_width_reg, PLANE_COLS);
      h = frame_dim(frame_height_reg, PLANE_ROWS);
      return !(sx < 0 || sy < 0 || sx > (w - 1) * FRAC_ONE || sy > (h - 1) * FRAC_ONE);
   endfunction

   // true when a sample at this point reads only pixels loaded since reset
   function automatic bit neighbors_loaded(input int sx, input int sy);
      int w, h, x0, y0, x1, y1;
      w = frame_dim(frame_width_reg, PLANE_COLS);
      h = frame_dim(frame_height_reg, PLANE_ROWS);
      if (!inside_plane(sx, sy)) return 1'b1;
      x0 = sx / FRAC_ONE;
      y0 = sy / FRAC_ONE;
      x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
      y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
      return plane_loaded[y0 * PLANE_COLS + x0] && plane_loaded[y0 * PLANE_COLS + x1] &&
             plane_loaded[y1 * PLANE_COLS + x0] && plane_loaded[y1 * PLANE_COLS + x1];
   endfunction

   function automatic longint pixel_at(input int x, input int y);
      return longint'($signed(plane_pixels[y * PLANE_COLS + x]));
   endfunction

   // applies one accepted item; returns 0 for a load the block drops
   function automatic bit warp_apply(input warp_req_type item);
      int               w, h, px, py, sx, sy, x0, y0, x1, y1, ax, ay;
      longint           acc;
      fbw_pkg::rsp_type result;
      w  = frame_dim(frame_width_reg, PLANE_COLS);
      h  = frame_dim(frame_height_reg, PLANE_ROWS);
      px = item.pos_x;
      py = item.pos_y;
      if (item.kind == fbw_pkg::REQ_LOAD) begin
         if (px >= w || py >= h) return 1'b0;
         plane_pixels[py * PLANE_COLS + px] = item.pixel;
         plane_loaded[py * PLANE_COLS + px] = 1'b1;
         return 1'b1;
      end
      sx = displaced(item.pos_x, item.flow_x);
      sy = displaced(item.pos_y, item.flow_y);
      result.sample_value  = '0;
      result.outside_frame = 1'b1;
      if (inside_plane(sx, sy)) begin
         x0 = sx / FRAC_ONE;
         y0 = sy / FRAC_ONE;
         ax = sx % FRAC_ONE;
         ay = sy % FRAC_ONE;
         x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
         y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
         acc = longint'((FRAC_ONE - ax) * (FRAC_ONE - ay)) * pixel_at(x0, y0)
             + longint'(ax * (FRAC_ONE - ay)) * pixel_at(x1, y0)
             + longint'((FRAC_ONE - ax) * ay) * pixel_at(x0, y1)
             + longint'(ax * ay) * pixel_at(x1, y1);
         // round half up, floor via arithmetic shift
         acc = (acc + (longint'(1) <<< (2 * fbw_pkg::FRAC_W - 1))) >>> (2 * fbw_pkg::FRAC_W);
         if (acc > 32767) acc = 32767;
         if (acc < -32768) acc = -32768;
         result.sample_value  = fbw_pkg::PIXEL_W'(acc);
         result.outside_frame = 1'b0;
      end
      pending_samples = {pending_samples, result};
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- items

   function automatic warp_req_type load_at(input int x, input int y, input int value);
      warp_req_type item;
      item.kind   = fbw_pkg::REQ_LOAD;
      item.pos_x  = fbw_pkg::POS_W'(x);
      item.pos_y  = fbw_pkg::POS_W'(y);
      item.pixel  = fbw_pkg::PIXEL_W'(value);
      item.flow_x = fbw_pkg::FLOW_W'($urandom);
      item.flow_y = fbw_pkg::FLOW_W'($urandom);
      return item;
   endfunction

   function automatic warp_req_type sample_at(input int x, input int y,
                                              input int fx, input int fy);
      warp_req_type item;
      item.kind   = fbw_pkg::REQ_SAMPLE;
      item.pos_x  = fbw_pkg::POS_W'(x);
      item.pos_y  = fbw_pkg::POS_W'(y);
      item.pixel  = fbw_pkg::PIXEL_W'($urandom);
      item.flow_x = fbw_pkg::FLOW_W'(fx);
      item.flow_y = fbw_pkg::FLOW_W'(fy);
      return item;
   endfunction

   function automatic int edge_pick(input int lim);
      case ($urandom_range(0, 4))
         0:       return -1;
         1:       return 0;
         2:       return lim;
         3:       return lim + 1;
         default: return $urandom_range(0, lim);
      endcase
   endfunction

   // sample whose point lands in the loaded box, on its edges, or anywhere
   function automatic warp_req_type make_sample(input int span_x, input int span_y);
      warp_req_type item;
      int           w, h, xlim, ylim, sx, sy, mode;
      w    = frame_dim(frame_width_reg, PLANE_COLS);
      h    = frame_dim(frame_height_reg, PLANE_ROWS);
      xlim = ((span_x < w) ? span_x - 1 : w - 1) * FRAC_ONE;
      ylim = ((span_y < h) ? span_y - 1 : h - 1) * FRAC_ONE;
      repeat (24) begin
         item.kind  = fbw_pkg::REQ_SAMPLE;
         item.pos_x = fbw_pkg::POS_W'($urandom);
         item.pos_y = fbw_pkg::POS_W'($urandom);
         item.pixel = fbw_pkg::PIXEL_W'($urandom);
         mode = $urandom_range(0, 99);
         sx = 0;
         sy = 0;
         if (mode < 65) begin
            sx = $urandom_range(0, xlim);
            sy = $urandom_range(0, ylim);
         end else if (mode < 85) begin
            sx = edge_pick(xlim);
            sy = edge_pick(ylim);
         end
         if (mode < 85) begin
            item.flow_x = fbw_pkg::FLOW_W'(sx - int'(item.pos_x) * FRAC_ONE);
            item.flow_y = fbw_pkg::FLOW_W'(sy - int'(item.pos_y) * FRAC_ONE);
         end else begin
            item.flow_x = fbw_pkg::FLOW_W'($urandom);
            item.flow_y = fbw_pkg::FLOW_W'($urandom);
         end
         if (neighbors_loaded(displaced(item.pos_x, item.flow_x),
                              displaced(item.pos_y, item.flow_y)))
            return item;
      end
      // fall back to a point just left of the plane
      item.flow_x = fbw_pkg::FLOW_W'(-1 - int'(item.pos_x) * FRAC_ONE);
      return item;
   endfunction

   // mostly samples, some reloads of pixels in the box
   function automatic warp_req_type next_item(input int span_x, input int span_y);
      int w, h;
      w = frame_dim(frame_width_reg, PLANE_COLS);
      h = frame_dim(frame_height_reg, PLANE_ROWS);
      if ($urandom_range(0, 99) < 15)
         return load_at($urandom_range(0, ((span_x < w) ? span_x : w) - 1),
                        $urandom_range(0, ((span_y < h) ? span_y : h) - 1), $urandom);
      return make_sample(span_x, span_y);
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_item(input warp_req_type item);
      if ($urandom_range(0, 99) < sender_gap_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_type        <= item.kind;
      req_pos_x       <= item.pos_x;
      req_pos_y       <= item.pos_y;
      req_pixel_value <= item.pixel;
      req_flow_x      <= item.flow_x;
      req_flow_y      <= item.flow_y;
      do @(posedge clock); while (req_full);
      if (warp_apply(item)) counted_items++;
   endtask

   // stop sending, wait for every result, then let trailing loads finish
   task automatic drain_results();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_samples.size() != 0);
      repeat (LOAD_SETTLE) @(posedge clock);
   endtask

   task automatic write_frame_reg(input logic [fbw_pkg::CSR_INDEX_W-1:0] index,
                                  input logic [fbw_pkg::CSR_DATA_W-1:0] value);
      drain_results();
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (index)
         fbw_pkg::CSR_FRAME_WIDTH:  frame_width_reg  = value;
         fbw_pkg::CSR_FRAME_HEIGHT: frame_height_reg = value;
         default: ;
      endcase
   endtask

   // set the frame, load a box of it fully, then mixed traffic inside
   task automatic run_plane_phase(input int w_reg, input int h_reg,
                                  input int span, input int n_items);
      int w, h, bx, by;
      write_frame_reg(fbw_pkg::CSR_FRAME_WIDTH, fbw_pkg::CSR_DATA_W'(w_reg));
      write_frame_reg(fbw_pkg::CSR_FRAME_HEIGHT, fbw_pkg::CSR_DATA_W'(h_reg));
      w  = frame_dim(frame_width_reg, PLANE_COLS);
      h  = frame_dim(frame_height_reg, PLANE_ROWS);
      bx = (span < w) ? span : w;
      by = (span < h) ? span : h;
      for (int y = 0; y < by; y++)
         for (int x = 0; x < bx; x++)
            send_item(load_at(x, y, $urandom));
      // loads past the plane edge are dropped
      if (w < PLANE_COLS)
         send_item(load_at($urandom_range(w, PLANE_COLS - 1), $urandom, $urandom));
      if (h < PLANE_ROWS)
         send_item(load_at($urandom, $urandom_range(h, PLANE_ROWS - 1), $urandom));
      repeat (n_items) send_item(next_item(span, span));
   endtask

   // ---------------------------------------------------------------- tests

   // reset frame size 512x512, corners of the plane, extreme flows
   task automatic test_default_frame();
      send_item(load_at(0, 0, 32767));
      send_item(load_at(1, 0, -32768));
      send_item(load_at(0, 1, 12345));
      send_item(load_at(1, 1, -1));
      send_item(load_at(510, 510, 100));
      send_item(load_at(511, 510, -200));
      send_item(load_at(510, 511, 300));
      send_item(load_at(511, 511, -400));
      send_item(sample_at(0, 0, 0, 0));
      send_item(sample_at(0, 0, 32, 32));
      send_item(sample_at(511, 511, 0, 0));     // both neighbors clamped
      send_item(sample_at(510, 510, 32, 48));
      send_item(sample_at(511, 510, 0, 32));    // right neighbor clamped
      send_item(sample_at(511, 511, 1, 0));     // just past the right edge
      send_item(sample_at(0, 0, 0, -1));        // just above the top edge
      send_item(sample_at(0, 511, 131071, -131072));
      send_item(sample_at(511, 0, -131072, 131071));
   endtask

   // 3x2 plane: rounding of exact halves, boundary column, far target
   task automatic test_small_frame();
      write_frame_reg(fbw_pkg::CSR_FRAME_WIDTH, 10'd3);
      write_frame_reg(fbw_pkg::CSR_FRAME_HEIGHT, 10'd2);
      send_item(load_at(0, 0, 1));
      send_item(load_at(1, 0, 0));
      send_item(load_at(2, 0, -1));
      send_item(load_at(0, 1, 7));
      send_item(load_at(1, 1, -7));
      send_item(load_at(2, 1, 32767));
      send_item(load_at(3, 0, 555));            // dropped: past width
      send_item(load_at(0, 2, 666));            // dropped: past height
      send_item(sample_at(0, 0, 32, 0));        // +0.5 rounds up to 1
      send_item(sample_at(1, 0, 32, 0));        // -0.5 rounds up to 0
      send_item(sample_at(400, 300, 2 * 64 - 400 * 64, 64 - 300 * 64));
      send_item(sample_at(2, 1, 1, 0));
      send_item(sample_at(2, 0, 0, 32));
   endtask

   // zero and oversize frame registers, spare register indexes
   task automatic test_size_limits();
      write_frame_reg(CSR_SPARE_2, fbw_pkg::CSR_DATA_W'($urandom));
      write_frame_reg(CSR_SPARE_3, fbw_pkg::CSR_DATA_W'($urandom));
      run_plane_phase(0, 1023, 16, 20);
      run_plane_phase(1023, 0, 16, 20);
   endtask

   task automatic test_random_planes();
      while (counted_items < 520) begin
         case ($urandom_range(0, 2))
            0:       sender_gap_pct = 0;
            1:       sender_gap_pct = 15;
            default: sender_gap_pct = 40;
         endcase
         case ($urandom_range(0, 2))
            0:       receiver_stall_pct = 0;
            1:       receiver_stall_pct = 15;
            default: receiver_stall_pct = 40;
         endcase
         run_plane_phase($urandom_range(1, 12), $urandom_range(1, 12), 16, 40);
      end
   endtask

   // receiver pauses fully while samples keep coming, then mixed traffic with random stalls
   task automatic test_backpressure();
      sender_gap_pct = 0;
      hold_results   = 1'b1;
      repeat (40) send_item(make_sample(16, 16));
      drain_results();
      sender_gap_pct     = 20;
      receiver_stall_pct = 30;
      repeat (20) send_item(next_item(16, 16));
   endtask

   task automatic test_back_to_back();
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
      repeat (60) send_item(next_item(16, 16));
   endtask

   // ---------------------------------------------------------------- result side

   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_results) begin
            hold_results = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if ($urandom_range(0, 99) < receiver_stall_pct) begin
            stall_left = $urandom_range(0, 7);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      fbw_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_samples.size() == 0) begin
            $error("unexpected result: sample_value %0d outside_frame %0b",
                   rsp_sample_value, rsp_outside_frame);
            failures++;
         end else begin
            want = pending_samples.pop_front();
            if (rsp_sample_value !== want.sample_value) begin
               $error("sample_value: expected %0d, got %0d",
                      want.sample_value, rsp_sample_value);
               failures++;
            end
            if (rsp_outside_frame !== want.outside_frame) begin
               $error("outside_frame: expected %0b, got %0b",
                      want.outside_frame, rsp_outside_frame);
               failures++;
            end
         end
      end
   end

   // counts cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $error("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("flow_bilinear_backward_warp verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset           <= 1'b1;
      req_push        <= 1'b0;
      req_type        <= fbw_pkg::REQ_LOAD;
      req_pos_x       <= '0;
      req_pos_y       <= '0;
      req_pixel_value <= '0;
      req_flow_x      <= '0;
      req_flow_y      <= '0;
      csr_write_en    <= 1'b0;
      csr_index       <= fbw_pkg::CSR_FRAME_WIDTH;
      csr_wdata       <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_frame();
      test_small_frame();
      test_size_limits();
      test_random_planes();
      test_backpressure();
      test_back_to_back();

      drain_results();
      repeat (END_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("flow_bilinear_backward_warp verification clean");
      else
         $display("flow_bilinear_backward_warp verification failed");
      $finish;
   end

endmodule

// ===== flow_bilinear_backward_warp.f =====
rtl/core/fbw_pkg.sv
rtl/core/fbw_fifo.sv
rtl/core/fbw_front.sv
rtl/core/fbw_back.sv
rtl/core/flow_bilinear_backward_warp.sv
bench/tb_flow_bilinear_backward_warp.sv
